>>> rtl/core/kde_pkg.sv
// ----------------------------------------------------------------------------
// kde_pkg
// Shared types, constants and helper functions for the keypad decimal entry
// and seven-segment display core.
// ----------------------------------------------------------------------------
package kde_pkg;

  // Field widths
  localparam int VALUE_W = 27;
  localparam int KEYS_W  = 10;
  localparam int SEG_W   = 32;
  localparam int KEY_W   = 4;

  // Entry stops (value freezes) at 10^(NUM_DIGITS-1)
  localparam int NUM_DIGITS = 8;

  function automatic int pow10(input int n);
    int t;
    t = 1;
    for (int i = 0; i < n; i++) begin
      t = t * 10;
    end
    return t;
  endfunction

  localparam logic [VALUE_W-1:0] FREEZE_THRESH = VALUE_W'(pow10(NUM_DIGITS - 1));

  // Reciprocal constants for division by 10^4, 100 and 10.
  // Rounded up; exact over the value ranges that reach each divider.
  localparam int                 DIV1E4_SH  = 41;
  localparam logic [27:0]        DIV1E4_MUL = 28'd219902326;
  localparam logic [26:0]        TEN_THOU   = 27'd10000;
  localparam int                 DIV100_SH  = 20;
  localparam logic [13:0]        DIV100_MUL = 14'd10486;
  localparam logic [13:0]        HUNDRED    = 14'd100;
  localparam logic [15:0]        DIV10_MUL  = 16'd205;
  localparam logic [7:0]         TEN        = 8'd10;

  // Input item: button mask and clear
  typedef struct packed {
    logic [KEYS_W-1:0] keys;
    logic              clear;
  } kde_key_t;

  // Result item: value, its seven-segment image and the frozen flag
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [SEG_W-1:0]   seg_low;
    logic [SEG_W-1:0]   seg_high;
    logic               done_res;
  } kde_res_t;

  // Active-high segment code, g in bit 6, a in bit 0; hex for 10..15
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      4'd10:   s = 8'h77;
      4'd11:   s = 8'h7C;
      4'd12:   s = 8'h39;
      4'd13:   s = 8'h5E;
      4'd14:   s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

  // Split x (0..134) into tens and ones, return {seg(tens), seg(ones)}
  function automatic logic [15:0] seg_pair(input logic [7:0] x);
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    prod = 16'(x) * DIV10_MUL;
    tens = prod[14:11];
    ones = x - 8'(tens) * TEN;
    return {seg_code(tens), seg_code(ones[3:0])};
  endfunction

endpackage

>>> rtl/core/keypad_decimal_entry_display_core.sv
// ----------------------------------------------------------------------------
// keypad_decimal_entry_display_core
// Builds a decimal number from key presses and shows it on eight digits.
// Throughput: one item per cycle unless res_ready holds the pipeline back;
// the stored number is updated in the accepting cycle by a shift-add
// (value*10 + key), the digit split follows in a five-stage pipeline
// (reciprocal multiplies by 10^4, 100 and 10).
// Reset: start value and stored number go to 0, pipeline empties.
// ----------------------------------------------------------------------------
module keypad_decimal_entry_display_core
  import kde_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata,
  input  logic               key_valid,
  output logic               key_ready,
  input  kde_key_t           key_item,
  output logic               res_valid,
  input  logic               res_ready,
  output kde_res_t           res_item
);

  // Configuration and stored number
  logic [VALUE_W-1:0] start_value;
  logic [VALUE_W-1:0] ev;
  logic [VALUE_W-1:0] ev_next;

  // Stage valids and advance enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en_out;

  // Stage payloads
  logic [VALUE_W-1:0] s1_value, s2_value, s3_value, s4_value, s5_value;
  logic               s1_done, s2_done, s3_done, s4_done, s5_done;
  logic [54:0]        s2_prod;
  logic [13:0]        s3_r, s3_q, s4_r, s4_q;
  logic [7:0]         s4_hi_r, s4_hi_q, s5_hi_r, s5_hi_q;
  logic [6:0]         s5_lo_r, s5_lo_q;

  // Front-end decode
  logic [KEY_W-1:0]   key;
  logic               accept;
  logic               emit;
  logic               frozen;

  // Stage math
  logic [13:0]        q;
  logic [26:0]        r_full;
  logic [27:0]        prod_r, prod_q;
  logic [13:0]        lo_r_full, lo_q_full;

  // Pipeline advance: a stage moves when empty or when the next one moves
  assign en_out    = !res_valid || res_ready;
  assign en5       = !v5 || en_out;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign key_ready = en1;

  assign accept = key_valid && key_ready;
  assign emit   = accept && !key_item.clear && (key_item.keys != '0);
  assign frozen = (ev >= FREEZE_THRESH);

  // Lowest set button gives key value index+1
  always_comb begin
    key = '0;
    for (int i = KEYS_W - 1; i >= 0; i--) begin
      if (key_item.keys[i]) begin
        key = KEY_W'(i + 1);
      end
    end
  end

  // value*10 + key, held once frozen
  always_comb begin
    ev_next = ev;
    if (!frozen) begin
      ev_next = {ev[VALUE_W-4:0], 3'b000} + {ev[VALUE_W-2:0], 1'b0} + VALUE_W'(key);
    end
  end

  // Stage math: divide by 10^4, then by 100, then remainders
  always_comb begin
    q         = s2_prod[54:DIV1E4_SH];
    r_full    = s2_value - 27'(q) * TEN_THOU;
    prod_r    = 28'(s3_r) * 28'(DIV100_MUL);
    prod_q    = 28'(s3_q) * 28'(DIV100_MUL);
    lo_r_full = s4_r - 14'(s4_hi_r) * HUNDRED;
    lo_q_full = s4_q - 14'(s4_hi_q) * HUNDRED;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= '0;
      ev          <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      v5          <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_value <= cfg_wdata;
      end
      if (accept && key_item.clear) begin
        ev <= start_value;
      end else if (emit) begin
        ev <= ev_next;
      end
      if (en1) v1 <= emit;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en_out) res_valid <= v5;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_value <= ev_next;
      s1_done  <= frozen;
    end
    if (en2) begin
      s2_value <= s1_value;
      s2_done  <= s1_done;
      s2_prod  <= 55'(s1_value) * 55'(DIV1E4_MUL);
    end
    if (en3) begin
      s3_value <= s2_value;
      s3_done  <= s2_done;
      s3_q     <= q;
      s3_r     <= r_full[13:0];
    end
    if (en4) begin
      s4_value <= s3_value;
      s4_done  <= s3_done;
      s4_r     <= s3_r;
      s4_q     <= s3_q;
      s4_hi_r  <= prod_r[27:DIV100_SH];
      s4_hi_q  <= prod_q[27:DIV100_SH];
    end
    if (en5) begin
      s5_value <= s4_value;
      s5_done  <= s4_done;
      s5_hi_r  <= s4_hi_r;
      s5_hi_q  <= s4_hi_q;
      s5_lo_r  <= lo_r_full[6:0];
      s5_lo_q  <= lo_q_full[6:0];
    end
    if (en_out) begin
      res_item.value    <= s5_value;
      res_item.done_res <= s5_done;
      res_item.seg_low  <= {seg_pair(s5_hi_r), seg_pair(8'(s5_lo_r))};
      res_item.seg_high <= {seg_pair(s5_hi_q), seg_pair(8'(s5_lo_q))};
    end
  end

  // A frozen result always carries a value at or above the threshold
  a_done_thresh: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.done_res) |-> (res_item.value >= FREEZE_THRESH))
    else $error("done result below threshold");

  // A press on a frozen number leaves it unchanged
  a_frozen_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !key_item.clear && frozen) |=> (ev == $past(ev)))
    else $error("frozen value changed");

  // Reciprocal division by 10^4 leaves a proper remainder
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (s3_r < 14'd10000))
    else $error("remainder by 10000 out of range");

  // Input stalls only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !key_ready |-> (v1 && v2 && v3 && v4 && v5 && res_valid))
    else $error("input stalled with a free stage");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for keypad_decimal_entry_display_core. A short scripted run covers
// key extremes, clear, lowest-bit priority, freezing and large start values.
// A random run follows under three sender/receiver stall mixes. Every result
// is checked field by field against fixed values or a model of entry logic.
// ----------------------------------------------------------------------------
module tb;
  import kde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FREEZE_AT = 10_000_000;
  localparam int          SETTLE    = 8;
  localparam int          PER_PHASE = 88;

  // Active-high segment codes for 0..15, entry d at bits [8*d +: 8]
  localparam logic [16*8-1:0] SEG_LUT = {
    8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef enum logic {ROW_PRESS, ROW_START} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    kde_key_t           item;
    logic [VALUE_W-1:0] start;
    bit                 has_typed;
    kde_res_t           typed;
  } entry_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [VALUE_W-1:0] cfg_wdata;
  logic               key_valid;
  logic               key_ready;
  kde_key_t           key_item;
  logic               res_valid;
  logic               res_ready;
  kde_res_t           res_item;

  // Model state: stored number and the start value register
  logic [VALUE_W-1:0] stored_num;
  logic [VALUE_W-1:0] start_mirror;

  kde_res_t   expected_res[$];
  entry_row_t script[$];
  int         errors;
  int         send_idle;
  int         recv_idle;

  keypad_decimal_entry_display_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_item  (key_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("FAIL keypad_decimal_entry_display_core");
    $finish;
  end

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Eight-digit segment image; top digit is value / 10^7 through the hex table
  function automatic void seg_image(input logic [VALUE_W-1:0] v,
                                    output logic [SEG_W-1:0] lo,
                                    output logic [SEG_W-1:0] hi);
    int unsigned r;
    logic [3:0]  d;
    r = v;
    for (int k = 0; k < 7; k++) begin
      d = 4'(r % 10);
      r = r / 10;
      if (k < 4) lo[8*k +: 8] = SEG_LUT[8*d +: 8];
      else hi[8*(k-4) +: 8] = SEG_LUT[8*d +: 8];
    end
    d = 4'(r & 15);
    hi[31:24] = SEG_LUT[8*d +: 8];
  endfunction

  // One accepted item: update the stored number, return 1 if a result is due
  function automatic bit entry_step(input kde_key_t it, output kde_res_t r);
    logic [3:0] key;
    bit         frozen;
    r = '0;
    if (it.clear) begin
      stored_num = start_mirror;
      return 1'b0;
    end
    if (it.keys == '0) return 1'b0;
    key = '0;
    for (int i = KEYS_W - 1; i >= 0; i--) begin
      if (it.keys[i]) key = 4'(i + 1);
    end
    frozen = stored_num >= FREEZE_AT;
    if (!frozen) stored_num = VALUE_W'(stored_num * 10 + key);
    r.value = stored_num;
    seg_image(stored_num, r.seg_low, r.seg_high);
    r.done_res = frozen;
    return 1'b1;
  endfunction

  function automatic entry_row_t row_press(logic [KEYS_W-1:0] keys, logic clr);
    entry_row_t row;
    row = '{ROW_PRESS, '0, '0, 1'b0, '0};
    row.item.keys = keys;
    row.item.clear = clr;
    return row;
  endfunction

  function automatic entry_row_t row_typed(logic [KEYS_W-1:0] keys, logic [VALUE_W-1:0] v,
                                           logic [SEG_W-1:0] lo, logic [SEG_W-1:0] hi,
                                           logic dn);
    entry_row_t row;
    row = row_press(keys, 1'b0);
    row.has_typed = 1'b1;
    row.typed.value = v;
    row.typed.seg_low = lo;
    row.typed.seg_high = hi;
    row.typed.done_res = dn;
    return row;
  endfunction

  function automatic entry_row_t row_start(logic [VALUE_W-1:0] v);
    entry_row_t row;
    row = '{ROW_START, '0, v, 1'b0, '0};
    return row;
  endfunction

  // Mostly single-key presses; clears get likely once the number is frozen
  function automatic kde_key_t rand_key();
    kde_key_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.keys = 10'(1 << $urandom_range(KEYS_W - 1));
    it.clear = 1'b0;
    if (pick < ((stored_num >= FREEZE_AT) ? 25 : 3)) begin
      it.clear = 1'b1;
      it.keys = 10'($urandom_range(1023));
    end else if (pick >= 92) begin
      it.keys = '0;
    end else if (pick >= 78) begin
      it.keys = 10'($urandom_range(1023));
    end
    return it;
  endfunction

  // Offer one item, wait for acceptance, then log its expected result
  task automatic send_key(kde_key_t it, bit has_typed, kde_res_t typed);
    kde_res_t r;
    while ($urandom_range(99) < send_idle) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid <= 1'b1;
    key_item <= it;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    if (entry_step(it, r)) expected_res.push_back(has_typed ? typed : r);
  endtask

  // Start value write, only once the pipeline has drained
  task automatic write_start(logic [VALUE_W-1:0] v);
    key_valid <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_mirror = v;
  endtask

  // Result side: random back-pressure and field checks
  initial begin
    kde_res_t want;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_valid && res_ready) begin
        if (expected_res.size() == 0) begin
          note_mismatch("unexpected result", 32'(res_item.value), '0);
        end else begin
          want = expected_res.pop_front();
          if (res_item.value !== want.value)
            note_mismatch("value", 32'(res_item.value), 32'(want.value));
          if (res_item.seg_low !== want.seg_low)
            note_mismatch("seg_low", res_item.seg_low, want.seg_low);
          if (res_item.seg_high !== want.seg_high)
            note_mismatch("seg_high", res_item.seg_high, want.seg_high);
          if (res_item.done_res !== want.done_res)
            note_mismatch("done_res", 32'(res_item.done_res), 32'(want.done_res));
        end
      end
      res_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Stimulus
  initial begin
    logic [VALUE_W-1:0] start_v;
    int                 counted;
    kde_key_t           it;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    key_valid = 1'b0;
    key_item = '0;
    errors = 0;
    send_idle = 25;
    recv_idle = 57;
    stored_num = '0;
    start_mirror = '0;

    // Scripted part
    script.push_back(row_press(10'h000, 1'b0));
    script.push_back(row_typed(10'h001, 27'd1, 32'h3F3F3F06, 32'h3F3F3F3F, 1'b0));
    script.push_back(row_press(10'h200, 1'b0));
    script.push_back(row_press(10'h3FF, 1'b0));
    script.push_back(row_press(10'h300, 1'b0));
    script.push_back(row_press(10'h3FF, 1'b1));
    for (int i = 0; i < 7; i++) script.push_back(row_press(10'h100, 1'b0));
    script.push_back(row_typed(10'h100, 27'd99999999, 32'h6F6F6F6F, 32'h6F6F6F6F, 1'b0));
    script.push_back(row_typed(10'h100, 27'd99999999, 32'h6F6F6F6F, 32'h6F6F6F6F, 1'b1));
    // Start value above the freeze point: frozen right after clear
    script.push_back(row_start(27'h7FFFFFF));
    script.push_back(row_press(10'h000, 1'b1));
    script.push_back(row_typed(10'h010, 27'h7FFFFFF, 32'h07075B07, 32'h5E665B06, 1'b1));
    // One digit short of freezing; clear beats the keys
    script.push_back(row_start(27'd9999999));
    script.push_back(row_press(10'h155, 1'b1));
    script.push_back(row_press(10'h020, 1'b0));
    script.push_back(row_press(10'h001, 1'b0));
    script.push_back(row_start(27'd0));
    script.push_back(row_press(10'h000, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_START) write_start(script[i].start);
      else send_key(script[i].item, script[i].has_typed, script[i].typed);
    end

    // Random part: six phases, two per stall mix
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: start_v = VALUE_W'($urandom_range(999));
        1: start_v = '0;
        2: start_v = VALUE_W'($urandom_range(999999));
        3: start_v = 27'h7FFFFFF;
        4: start_v = VALUE_W'($urandom_range(9999999));
        default: start_v = 27'd99999999;
      endcase
      write_start(start_v);
      if (p < 2) begin
        send_idle = 25;
        recv_idle = 57;
      end else if (p < 4) begin
        send_idle = 57;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      it = '0;
      it.clear = 1'b1;
      send_key(it, 1'b0, '0);
      counted = 0;
      while (counted < PER_PHASE) begin
        it = rand_key();
        send_key(it, 1'b0, '0);
        counted++;
      end
    end

    // Drain
    key_valid <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS keypad_decimal_entry_display_core");
    end else begin
      $display("FAIL keypad_decimal_entry_display_core");
    end
    $finish;
  end

endmodule

>>> keypad_decimal_entry_display_core.f
rtl/core/kde_pkg.sv
rtl/core/keypad_decimal_entry_display_core.sv
tb/tb.sv
